// ===== sv/assert_macros.svh =====
// Shared assertion shorthands; the asserting module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never be true.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/jns_pkg.sv =====
package jns_pkg;

	localparam int MANTISSA_WIDTH = 64;
	localparam int EXPONENT_WIDTH = 16;
	localparam int MANT_EXT_W     = MANTISSA_WIDTH + 4;
	localparam int EXP_EXT_W      = EXPONENT_WIDTH + 4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef logic [3:0] cls_t;

	localparam cls_t CL_ZERO      = 4'd0;
	localparam cls_t CL_DIGIT_MAX = 4'd9;
	localparam cls_t CL_MINUS     = 4'd10;
	localparam cls_t CL_PLUS      = 4'd11;
	localparam cls_t CL_E         = 4'd12;
	localparam cls_t CL_DOT       = 4'd13;
	localparam cls_t CL_OTHER     = 4'd14;

	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ZERO,
		ST_INT,
		ST_POINT,
		ST_FRAC,
		ST_EXP,
		ST_EXPSIGN,
		ST_EXPDIG
	} scan_state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       first;
	} item_t;

	typedef struct packed {
		logic first;
		cls_t cls;
	} mid_item_t;

	typedef struct packed {
		logic        status;
		logic        negative;
		logic [63:0] mantissa;
		logic [7:0]  frac_digits;
		logic        exp_negative;
		logic [15:0] exponent;
		logic        overflow;
	} result_t;

	typedef struct packed {
		logic emit_num;
		logic emit_err;
		logic acc_mant;
		logic acc_exp;
		logic inc_frac;
		logic set_sign;
		logic set_exp_sign;
	} action_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t cl;
		logic [7:0] diff;
		diff = c - CH_ZERO;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			cl = diff[3:0];
		end else if (c == CH_MINUS) begin
			cl = CL_MINUS;
		end else if (c == CH_PLUS) begin
			cl = CL_PLUS;
		end else if (c == CH_LOW_E || c == CH_UP_E) begin
			cl = CL_E;
		end else if (c == CH_DOT) begin
			cl = CL_DOT;
		end else begin
			cl = CL_OTHER;
		end
		return cl;
	endfunction

endpackage

// ===== sv/jns_front.sv =====
`include "assert_macros.svh"

module jns_front import jns_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  item_t     item,
	output logic      fwd_valid,
	input  logic      fwd_ready,
	output mid_item_t fwd_item
);

	logic      valid_s1;
	mid_item_t item_s1;
	logic      accept;

	assign full      = valid_s1 && !fwd_ready;
	assign accept    = push && !full;
	assign fwd_valid = valid_s1;
	assign fwd_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fwd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.first <= item.first;
			item_s1.cls   <= classify(item.char_in);
		end
	end

	`ASSERT_NEXT(a_hold_word, valid_s1 && !fwd_ready, valid_s1 && $stable(item_s1), "word lost")

endmodule

// ===== sv/jns_fifo.sv =====
`include "assert_macros.svh"

module jns_fifo import jns_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mid_item_t wdata,
	output logic      full,
	input  logic      pop,
	output mid_item_t rdata,
	output logic      empty
);

	mid_item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q;
	logic [FIFO_PTR_W-1:0] rptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + FIFO_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	`ASSERT_NEVER(a_pop_when_empty, pop && empty, "pop from empty queue")
	`ASSERT_NEVER(a_count_range, cnt_q > FIFO_CNT_W'(FIFO_DEPTH), "queue count out of range")

endmodule

// ===== sv/jns_back.sv =====
`include "assert_macros.svh"

module jns_back import jns_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  mid_item_t item,
	output logic      item_pop,
	output logic      empty,
	input  logic      pop,
	output result_t   result
);

	scan_state_t               state_q;
	scan_state_t               state_d;
	scan_state_t               cur_state;
	logic                      sign_q;
	logic [MANTISSA_WIDTH-1:0] mant_q;
	logic [7:0]                frac_q;
	logic                      exp_sign_q;
	logic [EXPONENT_WIDTH-1:0] exp_q;
	logic                      sat_q;

	logic                      base_sign;
	logic [MANTISSA_WIDTH-1:0] base_mant;
	logic [7:0]                base_frac;
	logic                      base_exp_sign;
	logic [EXPONENT_WIDTH-1:0] base_exp;
	logic                      base_sat;

	logic                      is_digit;
	logic                      start_minus;
	action_t                   act;

	logic [MANT_EXT_W-1:0]     mant_ext;
	logic [MANT_EXT_W-1:0]     mant_prod;
	logic                      mant_ovf;
	logic [MANTISSA_WIDTH-1:0] mant_new;
	logic [EXP_EXT_W-1:0]      exp_ext;
	logic [EXP_EXT_W-1:0]      exp_prod;
	logic                      exp_ovf;
	logic [EXPONENT_WIDTH-1:0] exp_new;
	logic                      frac_full;
	logic [31:0]               exp_wide;
	logic                      exp_clamp;

	logic                      emit;
	logic                      go;
	logic                      load;
	result_t                   result_d;
	result_t                   out_q;
	logic                      out_valid_q;

	assign cur_state     = item.first ? ST_START : state_q;
	assign base_sign     = item.first ? 1'b0 : sign_q;
	assign base_mant     = item.first ? '0 : mant_q;
	assign base_frac     = item.first ? '0 : frac_q;
	assign base_exp_sign = item.first ? 1'b0 : exp_sign_q;
	assign base_exp      = item.first ? '0 : exp_q;
	assign base_sat      = item.first ? 1'b0 : sat_q;

	assign is_digit    = (item.cls <= CL_DIGIT_MAX);
	assign start_minus = item.first && (item.cls == CL_MINUS);

	always_comb begin : next_state
		state_d = cur_state;
		if (start_minus) begin
			state_d = ST_START;
		end else begin
			case (cur_state)
				ST_START: begin
					if (!is_digit) begin
						state_d = ST_IDLE;
					end else if (item.cls == CL_ZERO) begin
						state_d = ST_ZERO;
					end else begin
						state_d = ST_INT;
					end
				end
				ST_ZERO, ST_INT: begin
					if (is_digit) begin
						state_d = (cur_state == ST_ZERO) ? ST_IDLE : ST_INT;
					end else if (item.cls == CL_E) begin
						state_d = ST_EXP;
					end else if (item.cls == CL_DOT) begin
						state_d = ST_POINT;
					end else begin
						state_d = ST_IDLE;
					end
				end
				ST_POINT, ST_FRAC: begin
					if (is_digit) begin
						state_d = ST_FRAC;
					end else if (cur_state == ST_FRAC && item.cls == CL_E) begin
						state_d = ST_EXP;
					end else begin
						state_d = ST_IDLE;
					end
				end
				ST_EXP, ST_EXPSIGN, ST_EXPDIG: begin
					if (is_digit) begin
						state_d = ST_EXPDIG;
					end else if (cur_state == ST_EXP &&
						(item.cls == CL_MINUS || item.cls == CL_PLUS)) begin
						state_d = ST_EXPSIGN;
					end else begin
						state_d = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin : actions
		act = '0;
		if (start_minus) begin
			act.set_sign = 1'b1;
		end else begin
			case (cur_state)
				ST_START: begin
					if (!is_digit) begin
						act.emit_err = 1'b1;
					end else if (item.cls != CL_ZERO) begin
						act.acc_mant = 1'b1;
					end
				end
				ST_ZERO, ST_INT: begin
					if (is_digit) begin
						if (cur_state == ST_ZERO) begin
							act.emit_err = 1'b1;
						end else begin
							act.acc_mant = 1'b1;
						end
					end else if (item.cls == CL_OTHER) begin
						act.emit_num = 1'b1;
					end else if (item.cls != CL_E && item.cls != CL_DOT) begin
						act.emit_err = 1'b1;
					end
				end
				ST_POINT, ST_FRAC: begin
					if (is_digit) begin
						act.acc_mant = 1'b1;
						act.inc_frac = 1'b1;
					end else if (cur_state == ST_FRAC && item.cls == CL_OTHER) begin
						act.emit_num = 1'b1;
					end else if (!(cur_state == ST_FRAC && item.cls == CL_E)) begin
						act.emit_err = 1'b1;
					end
				end
				ST_EXP, ST_EXPSIGN, ST_EXPDIG: begin
					if (is_digit) begin
						act.acc_exp = 1'b1;
					end else if (cur_state == ST_EXP &&
						(item.cls == CL_MINUS || item.cls == CL_PLUS)) begin
						act.set_exp_sign = 1'b1;
					end else if (cur_state == ST_EXPDIG && item.cls == CL_OTHER) begin
						act.emit_num = 1'b1;
					end else begin
						act.emit_err = 1'b1;
					end
				end
				default: begin
					act = '0;
				end
			endcase
		end
	end

	// times ten plus digit; any carry past the field width saturates
	assign mant_ext  = {4'b0, base_mant};
	assign mant_prod = (mant_ext << 3) + (mant_ext << 1) + MANT_EXT_W'(item.cls);
	assign mant_ovf  = (mant_prod[MANT_EXT_W-1:MANTISSA_WIDTH] != '0);
	assign mant_new  = mant_ovf ? '1 : mant_prod[MANTISSA_WIDTH-1:0];

	assign exp_ext  = {4'b0, base_exp};
	assign exp_prod = (exp_ext << 3) + (exp_ext << 1) + EXP_EXT_W'(item.cls);
	assign exp_ovf  = (exp_prod[EXP_EXT_W-1:EXPONENT_WIDTH] != '0);
	assign exp_new  = exp_ovf ? '1 : exp_prod[EXPONENT_WIDTH-1:0];

	assign frac_full = (base_frac == 8'hFF);
	assign exp_wide  = 32'(base_exp);
	assign exp_clamp = (exp_wide > 32'h0000_FFFF);

	always_comb begin
		result_d = '0;
		if (act.emit_err) begin
			result_d.status   = STATUS_ERROR;
			result_d.negative = base_sign;
		end else begin
			result_d.status       = STATUS_DONE;
			result_d.negative     = base_sign;
			result_d.mantissa     = 64'(base_mant);
			result_d.frac_digits  = base_frac;
			result_d.exp_negative = base_exp_sign;
			result_d.exponent     = exp_clamp ? 16'hFFFF : exp_wide[15:0];
			result_d.overflow     = base_sat || exp_clamp;
		end
	end

	assign emit     = act.emit_num || act.emit_err;
	assign go       = item_valid && (!emit || !out_valid_q || pop);
	assign load     = go && emit;
	assign item_pop = go;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sign_q      <= 1'b0;
			mant_q      <= '0;
			frac_q      <= '0;
			exp_sign_q  <= 1'b0;
			exp_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				state_q    <= state_d;
				sign_q     <= act.set_sign ? 1'b1 : base_sign;
				mant_q     <= act.acc_mant ? mant_new : base_mant;
				frac_q     <= (act.inc_frac && !frac_full) ? base_frac + 8'd1 : base_frac;
				exp_sign_q <= act.set_exp_sign ? (item.cls == CL_MINUS) : base_exp_sign;
				exp_q      <= act.acc_exp ? exp_new : base_exp;
				sat_q      <= base_sat || (act.acc_mant && mant_ovf) ||
					(act.acc_exp && exp_ovf) || (act.inc_frac && frac_full);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= result_d;
		end
	end

	`ASSERT_NEVER(a_no_overwrite, load && out_valid_q && !pop, "waiting result overwritten")
	`ASSERT_NEXT(a_idle_after_result, load, state_q == ST_IDLE, "scanner not idle after result")

endmodule

// ===== sv/json_number_scanner_top.sv =====
// JSON number scanner: one character word per cycle unless a full queue or a waiting result stalls it.
// A token's result reaches the result side after its ending word is accepted, passing the
// front classify register, the four-entry queue and the back result register in turn.
// Throughput: 1 word per cycle while no unpopped result stalls the back, whose times-ten update is combinational.
// Reset (arst_n low, asynchronous): scanner idle, front stage, queue and result register empty.
module json_number_scanner_top import jns_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic      fwd_valid;
	logic      fwd_ready;
	mid_item_t fwd_item;
	logic      q_full;
	logic      q_empty;
	mid_item_t q_item;
	logic      q_pop;

	assign fwd_ready = !q_full;

	jns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.fwd_valid (fwd_valid),
		.fwd_ready (fwd_ready),
		.fwd_item  (fwd_item)
	);

	jns_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fwd_valid),
		.wdata  (fwd_item),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_item),
		.empty  (q_empty)
	);

	jns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item       (q_item),
		.item_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
